// File: rtl/nsp_pkg.sv
`timescale 1ns / 1ps
// Package for the number string parser: parse phases, state and result types,
// character codes and the hex digit decoder. No dependencies.
package nsp_pkg;

  localparam int unsigned MAX_HEX_DIGITS_DEF = 8;
  localparam int unsigned MAX_DEC_DIGITS_DEF = 10;

  localparam int unsigned CH_W    = 8;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned POS_W   = 4;
  localparam int unsigned S_TDATA_W = 8;
  localparam int unsigned M_TDATA_W = 40;

  localparam logic [CH_W-1:0] CH_NUL  = 8'h00;
  localparam logic [CH_W-1:0] CH_0    = 8'h30;
  localparam logic [CH_W-1:0] CH_9    = 8'h39;
  localparam logic [CH_W-1:0] CH_A_LO = 8'h61;
  localparam logic [CH_W-1:0] CH_F_LO = 8'h66;
  localparam logic [CH_W-1:0] CH_A_UP = 8'h41;
  localparam logic [CH_W-1:0] CH_F_UP = 8'h46;
  localparam logic [CH_W-1:0] CH_X_LO = 8'h78;
  localparam logic [CH_W-1:0] CH_X_UP = 8'h58;
  localparam logic [CH_W-1:0] CH_K_LO = 8'h6b;
  localparam logic [CH_W-1:0] CH_K_UP = 8'h4b;
  localparam logic [CH_W-1:0] CH_M_LO = 8'h6d;
  localparam logic [CH_W-1:0] CH_M_UP = 8'h4d;

  localparam int unsigned KILO_SHIFT = 10;
  localparam int unsigned MEGA_SHIFT = 20;

  typedef enum logic [2:0] {
    PH_START  = 3'd0,
    PH_DEC    = 3'd1,
    PH_ZERO   = 3'd2,
    PH_HEXPRE = 3'd3,
    PH_HEX    = 3'd4,
    PH_SKIP   = 3'd5
  } phase_t;

  typedef struct packed {
    phase_t             phase;
    logic [POS_W-1:0]   char_pos;
    logic [VALUE_W-1:0] accum;
  } nsp_state_t;

  typedef struct packed {
    logic               emit;
    logic               ok;
    logic [VALUE_W-1:0] value;
  } nsp_result_t;

  // Returns {is_hex, digit value}.
  function automatic logic [4:0] hex_digit(input logic [CH_W-1:0] c);
    logic [4:0] r;
    r = '0;
    if (c >= CH_0 && c <= CH_9) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= CH_A_LO && c <= CH_F_LO) || (c >= CH_A_UP && c <= CH_F_UP)) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

endpackage

// File: rtl/number_string_parser_top.sv
`timescale 1ns / 1ps
// Top level of the number string parser: one character per transaction in,
// one result transaction per string out. Uses nsp_pkg, nsp_in_reg, nsp_step.
// A result reaches the output register once its deciding character has passed the input
// register and the parse step. Throughput: one character per cycle unless a result waits
// for m_tready, set by the single parse step between the input register and the state and result registers.
// Reset (rst, synchronous) empties the input and output registers and returns to string start.
module number_string_parser_top #(
  parameter int unsigned MAX_HEX_DIGITS = nsp_pkg::MAX_HEX_DIGITS_DEF,
  parameter int unsigned MAX_DEC_DIGITS = nsp_pkg::MAX_DEC_DIGITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [nsp_pkg::S_TDATA_W-1:0] s_tdata,  // [7:0] ch
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [nsp_pkg::M_TDATA_W-1:0] m_tdata   // [0] ok, [32:1] value, [39:33] zero
);
  import nsp_pkg::*;

  logic        held_valid;
  logic [CH_W-1:0] held_ch;
  logic        take;
  logic        out_free;
  nsp_state_t  st;
  nsp_state_t  st_next;
  nsp_result_t res;
  logic        out_ok;
  logic [VALUE_W-1:0] out_value;

  nsp_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_ch       (s_tdata[CH_W-1:0]),
    .take       (take),
    .held_valid (held_valid),
    .held_ch    (held_ch)
  );

  nsp_step #(
    .MAX_HEX_DIGITS (MAX_HEX_DIGITS),
    .MAX_DEC_DIGITS (MAX_DEC_DIGITS)
  ) u_step (
    .st      (st),
    .ch      (held_ch),
    .st_next (st_next),
    .res     (res)
  );

  assign out_free = !m_tvalid || m_tready;
  assign take     = held_valid && (!res.emit || out_free);

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '{phase: PH_START, char_pos: '0, accum: '0};
    end else if (take) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (take && res.emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && res.emit) begin
      out_ok    <= res.ok;
      out_value <= res.value;
    end
  end

  assign m_tdata = {{(M_TDATA_W-VALUE_W-1){1'b0}}, out_value, out_ok};

  a_fail_value_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !out_ok |-> out_value == '0)
    else $error("failed parse carries a nonzero value");

  a_emit_loads_out: assert property (@(posedge clk) disable iff (rst)
    take && res.emit |=> m_tvalid)
    else $error("result lost after the deciding character");

  a_skip_silent: assert property (@(posedge clk) disable iff (rst)
    held_valid && st.phase == PH_SKIP |-> !res.emit)
    else $error("result emitted while skipping");

  a_pos_bound: assert property (@(posedge clk) disable iff (rst)
    (st.phase == PH_HEX || st.phase == PH_HEXPRE) ?
      (st.char_pos <= POS_W'(MAX_HEX_DIGITS)) : (st.char_pos <= POS_W'(MAX_DEC_DIGITS)))
    else $error("digit count beyond its limit");

endmodule

// File: rtl/nsp_in_reg.sv
`timescale 1ns / 1ps
// Input register stage of the number string parser.
// Holds one character until the parse step takes it. Uses nsp_pkg.
module nsp_in_reg (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [nsp_pkg::CH_W-1:0]  s_ch,
  input  logic                      take,
  output logic                      held_valid,
  output logic [nsp_pkg::CH_W-1:0]  held_ch
);
  import nsp_pkg::*;

  assign s_tready = !held_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (s_tready) begin
      held_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      held_ch <= s_ch;
    end
  end

endmodule

// File: rtl/nsp_step.sv
`timescale 1ns / 1ps
// Parse step of the number string parser: next state and the optional result
// for one character. Purely combinational. Uses nsp_pkg.
module nsp_step #(
  parameter int unsigned MAX_HEX_DIGITS = nsp_pkg::MAX_HEX_DIGITS_DEF,
  parameter int unsigned MAX_DEC_DIGITS = nsp_pkg::MAX_DEC_DIGITS_DEF
) (
  input  nsp_pkg::nsp_state_t       st,
  input  logic [nsp_pkg::CH_W-1:0]  ch,
  output nsp_pkg::nsp_state_t       st_next,
  output nsp_pkg::nsp_result_t      res
);
  import nsp_pkg::*;

  localparam logic [POS_W-1:0] HEX_LIMIT = POS_W'(MAX_HEX_DIGITS);
  localparam logic [POS_W-1:0] DEC_LIMIT = POS_W'(MAX_DEC_DIGITS);

  logic               is_dec;
  logic [4:0]         hex;
  logic [VALUE_W-1:0] accum_dec;
  logic [VALUE_W-1:0] accum_hex;
  nsp_state_t         dec_st;
  nsp_result_t        dec_res;

  assign is_dec    = (ch >= CH_0) && (ch <= CH_9);
  assign hex       = hex_digit(ch);
  assign accum_dec = (st.accum << 3) + (st.accum << 1) + {{(VALUE_W-4){1'b0}}, ch[3:0]};
  assign accum_hex = {st.accum[VALUE_W-5:0], hex[3:0]};

  // Decimal handling once at least one digit has been taken.
  always_comb begin
    dec_st  = '{phase: PH_SKIP, char_pos: '0, accum: '0};
    dec_res = '{emit: 1'b1, ok: 1'b0, value: '0};
    if (ch == CH_NUL) begin
      dec_st.phase  = PH_START;
      dec_res.ok    = 1'b1;
      dec_res.value = st.accum;
    end else if (ch == CH_K_LO || ch == CH_K_UP) begin
      dec_res.ok    = 1'b1;
      dec_res.value = st.accum << KILO_SHIFT;
    end else if (ch == CH_M_LO || ch == CH_M_UP) begin
      dec_res.ok    = 1'b1;
      dec_res.value = st.accum << MEGA_SHIFT;
    end else if (is_dec && st.char_pos < DEC_LIMIT) begin
      dec_st  = '{phase: PH_DEC, char_pos: st.char_pos + 1'b1, accum: accum_dec};
      dec_res = '0;
    end
  end

  always_comb begin
    st_next = st;
    res     = '0;
    unique case (st.phase) inside
      PH_SKIP: begin
        if (ch == CH_NUL) begin
          st_next = '{phase: PH_START, char_pos: '0, accum: '0};
        end
      end
      PH_DEC, PH_ZERO: begin
        if (st.phase == PH_ZERO && (ch == CH_X_LO || ch == CH_X_UP)) begin
          st_next = '{phase: PH_HEXPRE, char_pos: '0, accum: '0};
        end else begin
          st_next = dec_st;
          res     = dec_res;
        end
      end
      PH_HEXPRE, PH_HEX: begin
        if (ch == CH_NUL) begin
          st_next = '{phase: PH_START, char_pos: '0, accum: '0};
          res.emit = 1'b1;
          if (st.phase == PH_HEX) begin
            res.ok    = 1'b1;
            res.value = st.accum;
          end
        end else if (!hex[4] || st.char_pos >= HEX_LIMIT) begin
          st_next  = '{phase: PH_SKIP, char_pos: '0, accum: '0};
          res.emit = 1'b1;
        end else begin
          st_next = '{phase: PH_HEX, char_pos: st.char_pos + 1'b1, accum: accum_hex};
        end
      end
      default: begin
        if (ch == CH_NUL) begin
          st_next  = '{phase: PH_START, char_pos: '0, accum: '0};
          res.emit = 1'b1;
          res.ok   = 1'b1;
        end else if (is_dec) begin
          st_next = '{phase: (ch == CH_0) ? PH_ZERO : PH_DEC, char_pos: POS_W'(1),
                      accum: {{(VALUE_W-4){1'b0}}, ch[3:0]}};
        end else begin
          st_next  = '{phase: PH_SKIP, char_pos: '0, accum: '0};
          res.emit = 1'b1;
        end
      end
    endcase
  end

endmodule
